>>> hw/rtl/button_gesture_classifier_assert.svh
// ----------------------------------------------------------------------------
// Button gesture classifier assertion macros
// Concurrent check shorthands shared by the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define BGC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BGC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Gesture codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bgc_pkg;

   localparam int unsigned SKIP_W     = 8;
   localparam int unsigned LIMIT_W    = 16;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [SKIP_W-1:0]  CHECK_SKIP_RESET  = 8'd0;
   localparam logic [SKIP_W-1:0]  SKIP_COUNT_RESET  = 8'd255;
   localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET    = 16'd30;
   localparam logic [LIMIT_W-1:0] LONG_HOLD_RESET   = 16'd2000;
   localparam logic [LIMIT_W-1:0] DOUBLE_GAP_RESET  = 16'd250;

   typedef enum logic [1:0] {
      GESTURE_NONE   = 2'd0,
      GESTURE_CLICK  = 2'd1,
      GESTURE_DOUBLE = 2'd2,
      GESTURE_LONG   = 2'd3
   } gesture_type;

   typedef enum logic [1:0] {
      CSR_CHECK_SKIP = 2'd0,
      CSR_DEBOUNCE   = 2'd1,
      CSR_LONG_HOLD  = 2'd2,
      CSR_DOUBLE_GAP = 2'd3
   } csr_index_type;

endpackage

>>> hw/rtl/bgc_req_if.sv
// ----------------------------------------------------------------------------
// Button gesture classifier tick channel
// Valid/ready channel carrying one sampled button level per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bgc_req_if;
   logic valid;
   logic ready;
   logic key_level;

   modport source (output valid, output key_level, input ready);
   modport sink   (input valid, input key_level, output ready);
endinterface

>>> hw/rtl/bgc_rsp_if.sv
// ----------------------------------------------------------------------------
// Button gesture classifier event channel
// Valid/ready channel carrying one gesture code per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bgc_rsp_if
   import bgc_pkg::*;
;
   logic        valid;
   logic        ready;
   gesture_type gesture;

   modport source (output valid, output gesture, input ready);
   modport sink   (input valid, input gesture, output ready);
endinterface

>>> hw/rtl/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// Button gesture classifier
// Debounces a sampled active-low button and reports click, double click and
// long press events, one result beat for every tick beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one timer tick per beat with the sampled key level
//   (0 pressed, 1 released). rsp_ch returns one gesture code per tick beat,
//   in order: none, click, double click or long press.
//   csr_* writes the prescale and limit registers; write only while idle.
//   Result: the code is registered in the output register or skid stage.
//   Throughput: one tick per cycle while req_ch.ready is high; the state update is
//   a single pass of compares and saturating increments between the state registers.
//   Stall: an output register plus a one-beat skid stage hold results;
//   req_ch.ready drops only while the skid stage is occupied.
//   Reset: registers return to their defaults (skip 0, debounce 30,
//   long hold 2000, double gap 250); the prescaler starts so the first
//   tick is evaluated, and both channels are empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "button_gesture_classifier_assert.svh"

module button_gesture_classifier
   import bgc_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   bgc_req_if.sink               req_ch,
   bgc_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int unsigned CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

   logic [SKIP_W-1:0]      check_skip_ff;
   logic [LIMIT_W-1:0]     debounce_ticks_ff;
   logic [LIMIT_W-1:0]     long_hold_ff;
   logic [LIMIT_W-1:0]     double_gap_ff;

   logic [SKIP_W-1:0]      skip_count_ff, skip_count_in;
   logic                   accepted_level_ff, accepted_level_in;
   logic [COUNT_WIDTH-1:0] debounce_count_ff, debounce_count_in;
   logic [COUNT_WIDTH-1:0] hold_count_ff, hold_count_in;
   logic                   armed_ff, armed_in;
   logic                   wait_release_ff, wait_release_in;
   logic                   wait_double_ff, wait_double_in;
   logic                   ignore_release_ff, ignore_release_in;

   logic                   rsp_valid_ff;
   gesture_type            rsp_gesture_ff;
   logic                   skid_valid_ff;
   gesture_type            skid_gesture_ff;

   logic                   accept;
   logic                   take;
   logic                   evaluate;
   logic                   change_done;
   gesture_type            gesture_in;
   logic [COUNT_WIDTH-1:0] hold_step;

   logic [CMP_W-1:0]       deb_cnt_x;
   logic [CMP_W-1:0]       deb_lim_x;
   logic [CMP_W-1:0]       hold_x;
   logic [CMP_W-1:0]       long_x;
   logic [CMP_W-1:0]       gap_x;

   assign accept        = req_ch.valid && req_ch.ready;
   assign take          = rsp_valid_ff && rsp_ch.ready;
   assign req_ch.ready  = !skid_valid_ff;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.gesture = rsp_gesture_ff;

   assign evaluate    = (skip_count_ff >= check_skip_ff);
   assign hold_step   = (hold_count_ff != '1) ? hold_count_ff + 1'b1 : hold_count_ff;
   assign deb_cnt_x   = CMP_W'(debounce_count_ff);
   assign deb_lim_x   = CMP_W'(debounce_ticks_ff);
   assign long_x      = CMP_W'(long_hold_ff);
   assign gap_x       = CMP_W'(double_gap_ff);
   assign hold_x      = CMP_W'(hold_step);
   assign change_done = (req_ch.key_level != accepted_level_ff) && (deb_cnt_x >= deb_lim_x);

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         check_skip_ff     <= CHECK_SKIP_RESET;
         debounce_ticks_ff <= DEBOUNCE_RESET;
         long_hold_ff      <= LONG_HOLD_RESET;
         double_gap_ff     <= DOUBLE_GAP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHECK_SKIP: check_skip_ff     <= csr_wr_data[SKIP_W-1:0];
            CSR_DEBOUNCE:   debounce_ticks_ff <= csr_wr_data[LIMIT_W-1:0];
            CSR_LONG_HOLD:  long_hold_ff      <= csr_wr_data[LIMIT_W-1:0];
            CSR_DOUBLE_GAP: double_gap_ff     <= csr_wr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // gesture state update
   always_comb begin
      skip_count_in     = skip_count_ff;
      accepted_level_in = accepted_level_ff;
      debounce_count_in = debounce_count_ff;
      hold_count_in     = hold_count_ff;
      armed_in          = armed_ff;
      wait_release_in   = wait_release_ff;
      wait_double_in    = wait_double_ff;
      ignore_release_in = ignore_release_ff;
      gesture_in        = GESTURE_NONE;

      if (!evaluate) begin
         skip_count_in = skip_count_ff + 1'b1;
      end else begin
         skip_count_in = '0;
         if (req_ch.key_level != accepted_level_ff) begin
            if (deb_cnt_x < deb_lim_x) begin
               if (debounce_count_ff != '1) begin
                  debounce_count_in = debounce_count_ff + 1'b1;
               end
            end else begin
               if (deb_cnt_x == deb_lim_x) begin
                  hold_count_in = '0;
               end
               armed_in          = 1'b1;
               accepted_level_in = req_ch.key_level;
               debounce_count_in = '0;
            end
         end else if (armed_ff) begin
            hold_count_in = hold_step;
            if (!req_ch.key_level) begin
               if (hold_x > long_x) begin
                  gesture_in        = GESTURE_LONG;
                  wait_release_in   = 1'b0;
                  ignore_release_in = 1'b1;
                  armed_in          = 1'b0;
                  wait_double_in    = 1'b0;
               end
               if (wait_double_in) begin
                  gesture_in        = GESTURE_DOUBLE;
                  wait_double_in    = 1'b0;
                  wait_release_in   = 1'b0;
                  ignore_release_in = 1'b1;
               end else if (!ignore_release_in) begin
                  wait_release_in = 1'b1;
               end
            end else begin
               ignore_release_in = 1'b0;
               if (wait_release_ff) begin
                  if (hold_x > gap_x) begin
                     gesture_in      = GESTURE_CLICK;
                     hold_count_in   = '0;
                     wait_release_in = 1'b0;
                     wait_double_in  = 1'b0;
                  end else begin
                     wait_release_in = 1'b1;
                     wait_double_in  = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_count_ff     <= SKIP_COUNT_RESET;
         accepted_level_ff <= 1'b1;
         debounce_count_ff <= '0;
         hold_count_ff     <= '0;
         armed_ff          <= 1'b0;
         wait_release_ff   <= 1'b0;
         wait_double_ff    <= 1'b0;
         ignore_release_ff <= 1'b0;
      end else if (accept) begin
         skip_count_ff     <= skip_count_in;
         accepted_level_ff <= accepted_level_in;
         debounce_count_ff <= debounce_count_in;
         hold_count_ff     <= hold_count_in;
         armed_ff          <= armed_in;
         wait_release_ff   <= wait_release_in;
         wait_double_ff    <= wait_double_in;
         ignore_release_ff <= ignore_release_in;
      end
   end

   // result beat: output register plus skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            rsp_gesture_ff <= skid_gesture_ff;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_gesture_ff <= gesture_in;
         end else begin
            skid_gesture_ff <= gesture_in;
         end
      end
   end

   `BGC_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff,
      "skid stage holds a beat while output register is empty")
   `BGC_ASSERT_IMPL(a_double_needs_release, clock, reset, wait_double_ff, wait_release_ff,
      "double click wait set without release wait")
   `BGC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid_ff && !skid_valid_ff,
      "result beat present right after reset")
   `BGC_ASSERT_NEXT(a_change_arms, clock, reset, accept && evaluate && change_done,
      armed_ff && (accepted_level_ff == $past(req_ch.key_level)),
      "accepted level change did not arm detection")

endmodule
